// ----- hdl/keyword_substitution_decipher_top_defines.svh -----
`ifndef KEYWORD_SUBSTITUTION_DECIPHER_TOP_DEFINES_SVH
`define KEYWORD_SUBSTITUTION_DECIPHER_TOP_DEFINES_SVH

// Check a condition at every edge outside reset.
`define KWS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Check a consequence in the same cycle.
`define KWS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the next cycle.
`define KWS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/kws_pkg.sv -----
`default_nettype none
package kws_pkg;

    localparam int unsigned LETTERS = 26;
    localparam logic [7:0] ASCII_A = 8'h61;
    localparam logic [7:0] ASCII_Z = 8'h7a;

    typedef logic [4:0] idx_t;
    typedef logic [4:0] pos_t;
    typedef logic [4:0] len_t;
    typedef logic [LETTERS-1:0] mask_t;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_KEY    = 2'd1,
        OP_CIPHER = 2'd2
    } op_t;

    typedef struct packed {
        logic en;
        idx_t addr;
        pos_t data;
    } ram_wr_t;

    typedef struct packed {
        logic cipher;
        logic hit;
        pos_t free_pos;
    } lookup_t;

endpackage
`default_nettype wire

// ----- hdl/kws_ram.sv -----
`default_nettype none
module kws_ram #(
    parameter int unsigned DEPTH = 26,
    parameter int unsigned WIDTH = 5,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ----- hdl/kws_front.sv -----
`default_nettype none
`include "keyword_substitution_decipher_top_defines.svh"
module kws_front
    import kws_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       accept,
    input  wire logic [1:0] op,
    input  wire logic [7:0] data_byte,
    output ram_wr_t         wr,
    output logic            rd_en,
    output idx_t            rd_addr,
    output lookup_t         lookup
);

    mask_t mask_reg, mask_next;
    len_t  len_reg, len_next;

    logic       is_letter;
    idx_t       idx;
    logic       in_key;
    mask_t      below_mask;
    logic [5:0] free_cnt;
    logic [5:0] free_sum;
    op_t        op_code;

    assign op_code   = op_t'(op);
    assign is_letter = (data_byte >= ASCII_A) && (data_byte <= ASCII_Z);
    assign idx       = is_letter ? 5'(data_byte - ASCII_A) : '0;
    assign in_key    = mask_reg[idx];
    assign below_mask = (mask_t'(1) << idx) - mask_t'(1);

    always_comb begin
        free_cnt = '0;
        for (int i = 0; i < LETTERS; i++) begin
            free_cnt = free_cnt + 6'(below_mask[i] & ~mask_reg[i]);
        end
    end

    assign free_sum = 6'(len_reg) + free_cnt;

    always_comb begin
        lookup.cipher   = (op_code == OP_CIPHER) && is_letter;
        lookup.hit      = in_key;
        lookup.free_pos = (free_sum >= 6'(LETTERS)) ? 5'(LETTERS - 1) : free_sum[4:0];
    end

    assign rd_en   = accept && (op_code == OP_CIPHER);
    assign rd_addr = idx;

    always_comb begin
        mask_next = mask_reg;
        len_next  = len_reg;
        wr.en     = 1'b0;
        wr.addr   = idx;
        wr.data   = len_reg;
        if (accept) begin
            unique case (op_code)
                OP_CLEAR: begin
                    mask_next = '0;
                    len_next  = '0;
                end
                OP_KEY: begin
                    if (is_letter && !in_key && (len_reg < 5'(LETTERS))) begin
                        wr.en          = 1'b1;
                        len_next       = len_reg + 5'd1;
                        mask_next[idx] = 1'b1;
                    end
                end
                OP_CIPHER: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
            len_reg  <= '0;
        end else begin
            mask_reg <= mask_next;
            len_reg  <= len_next;
        end
    end

    `KWS_ASSERT_ALWAYS(a_len_matches_mask, $countones(mask_reg) == 32'(len_reg), "key length off")
    `KWS_ASSERT_ALWAYS(a_len_in_range, len_reg <= 5'(LETTERS), "key length too large")
    `KWS_ASSERT_NEXT(a_clear_empties, accept && (op_code == OP_CLEAR), mask_reg == '0, "clear missed")

endmodule
`default_nettype wire

// ----- hdl/keyword_substitution_decipher_top.sv -----
// Channel | Direction | tdata                  | tuser
// s_      | in        | [7:0] data_byte        | [1:0] op
// m_      | out       | [6:0] plain_byte, [7]0 | -
//
// Accepts one transaction per cycle while s_tready is high; results pass s1, then m_data_reg.
// The key position memory is read in the accept cycle and its data is ready in the next cycle.
// A key write lands at acceptance, so a following ciphertext byte sees it without a bubble.
// aresetn is synchronous, active low, and empties the key; no clearing pass is needed.
// A stalled m_ side holds the output register and then the lookup stage before s_tready drops.
`default_nettype none
`include "keyword_substitution_decipher_top_defines.svh"
module keyword_substitution_decipher_top
    import kws_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,  // [7:0] data_byte
    input  wire logic [1:0] s_tuser,  // [1:0] op
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic      [7:0] m_tdata   // [6:0] plain_byte, [7] zero
);

    logic    accept;
    logic    out_free;
    ram_wr_t wr;
    logic    rd_en;
    idx_t    rd_addr;
    pos_t    rd_data;
    lookup_t lookup;

    logic s1_valid_reg, s1_valid_next;
    logic s1_hit_reg;
    pos_t s1_free_reg;
    logic m_valid_reg, m_valid_next;
    logic [6:0] m_data_reg;
    pos_t pos;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    kws_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .op        (s_tuser),
        .data_byte (s_tdata),
        .wr        (wr),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .lookup    (lookup)
    );

    kws_ram #(
        .DEPTH (LETTERS),
        .WIDTH (5)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr.en),
        .wr_addr (wr.addr),
        .wr_data (wr.data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign pos = s1_hit_reg ? rd_data : s1_free_reg;

    always_comb begin
        priority if (accept) begin
            s1_valid_next = lookup.cipher;
        end else if (out_free) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
        m_valid_next = out_free ? s1_valid_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_hit_reg  <= lookup.hit;
            s1_free_reg <= lookup.free_pos;
        end
        if (out_free && s1_valid_reg) begin
            m_data_reg <= ASCII_A[6:0] + 7'(pos);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_data_reg};

    `KWS_ASSERT_SAME(a_out_letter, m_tvalid, (m_tdata >= ASCII_A) && (m_tdata <= ASCII_Z), "bad letter")
    `KWS_ASSERT_SAME(a_stall_blocks, s1_valid_reg && !out_free, !s_tready, "accept while full")
    `KWS_ASSERT_NEXT(a_cipher_enters, accept && lookup.cipher, s1_valid_reg, "lookup lost")

endmodule
`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import kws_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int DIRECTED_ITEMS = 24;
    localparam int RANDOM_ITEMS = 750;
    localparam int CYCLE_LIMIT = 300000;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data_byte;
    } kws_item_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'd0;   // [7:0] data_byte
    logic [1:0] s_tuser = 2'd0;   // [1:0] op
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;          // [6:0] plain_byte, [7] zero

    kws_item_t  feed_q[$];
    logic [6:0] plain_q[$];

    logic [LETTERS-1:0] key_mask;
    int                 key_slot[LETTERS];
    int                 key_len;

    int n_items;
    int sent_cnt = 0;
    int recv_cnt = 0;
    int err_cnt = 0;
    int clear_cnt = 0;
    int key_cnt = 0;
    int full_key_cnt = 0;
    int cycle_cnt = 0;
    int src_idle;
    int sink_idle;

    keyword_substitution_decipher_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    task automatic decipher_step(input logic [1:0] op, input logic [7:0] b);
        logic is_letter;
        int   idx;
        int   pos;
        is_letter = (b >= ASCII_A) && (b <= ASCII_Z);
        idx = is_letter ? int'(b - ASCII_A) : 0;
        case (op)
            OP_CLEAR: begin
                key_mask = '0;
                key_len = 0;
                clear_cnt++;
            end
            OP_KEY: begin
                if (is_letter && !key_mask[idx] && key_len < LETTERS) begin
                    key_slot[idx] = key_len;
                    key_len++;
                    key_mask[idx] = 1'b1;
                    key_cnt++;
                    if (key_len == LETTERS)
                        full_key_cnt++;
                end
            end
            OP_CIPHER: begin
                if (is_letter) begin
                    if (key_mask[idx]) begin
                        pos = key_slot[idx];
                    end else begin
                        pos = key_len;
                        for (int i = 0; i < idx; i++)
                            if (!key_mask[i])
                                pos++;
                    end
                    if (pos >= LETTERS)
                        pos = LETTERS - 1;
                    plain_q.push_back(7'(int'(ASCII_A) + pos));
                end
            end
            default: ;
        endcase
    endtask

    task automatic queue_item(input logic [1:0] op, input logic [7:0] b);
        kws_item_t item;
        item.op = op;
        item.data_byte = b;
        feed_q.push_back(item);
    endtask

    function automatic logic [7:0] any_letter();
        return 8'(int'(ASCII_A) + $urandom_range(0, LETTERS - 1));
    endfunction

    always_comb begin
        if (sent_cnt < n_items / 3) begin
            src_idle = 35;
            sink_idle = 61;
        end else if (sent_cnt < 2 * n_items / 3) begin
            src_idle = 61;
            sink_idle = 35;
        end else begin
            src_idle = 0;
            sink_idle = 0;
        end
    end

    // feed transactions and predict on acceptance
    always @(posedge aclk) begin
        kws_item_t item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'd0;
            s_tuser <= OP_CLEAR;
        end else begin
            if (s_tvalid && s_tready) begin
                sent_cnt <= sent_cnt + 1;
                decipher_step(s_tuser, s_tdata);
            end
            if (!s_tvalid || s_tready) begin
                if (feed_q.size() > 0 && $urandom_range(0, 99) >= src_idle) begin
                    item = feed_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= item.data_byte;
                    s_tuser <= item.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // check results against the oldest expected letter
    always @(posedge aclk) begin
        logic [6:0] want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                recv_cnt <= recv_cnt + 1;
                if (plain_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("tb: unexpected result plain_byte=%h", m_tdata[6:0]);
                end else begin
                    want = plain_q.pop_front();
                    if (m_tdata[6:0] !== want) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("tb: plain_byte mismatch expected=%h actual=%h",
                                     want, m_tdata[6:0]);
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= sink_idle);
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb: timeout with %0d items sent, %0d results pending",
                     sent_cnt, plain_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int perm[LETTERS];
        int klen;
        int clen;
        int j;
        int tmp;
        key_mask = '0;
        key_len = 0;
        foreach (key_slot[i])
            key_slot[i] = 0;

        // directed: reset state, byte extremes, repeats, unused op
        queue_item(OP_CIPHER, "a");
        queue_item(OP_CIPHER, "z");
        queue_item(OP_CIPHER, 8'h60);
        queue_item(OP_CIPHER, 8'h7b);
        queue_item(OP_KEY, "z");
        queue_item(OP_KEY, "e");
        queue_item(OP_KEY, "z");
        queue_item(OP_KEY, "A");
        queue_item(OP_KEY, 8'h00);
        queue_item(OP_KEY, 8'hff);
        queue_item(OP_KEY, "a");
        queue_item(OP_UNUSED, "b");
        queue_item(OP_CIPHER, "a");
        queue_item(OP_CIPHER, "b");
        queue_item(OP_CIPHER, "c");
        queue_item(OP_CIPHER, "z");
        queue_item(OP_CIPHER, 8'h00);
        queue_item(OP_CIPHER, 8'hff);
        queue_item(OP_CIPHER, "Z");
        queue_item(OP_CLEAR, 8'hff);
        queue_item(OP_CIPHER, "e");
        queue_item(OP_UNUSED, 8'h00);
        queue_item(OP_CLEAR, 8'h00);
        queue_item(OP_CIPHER, "z");

        while (feed_q.size() < DIRECTED_ITEMS + RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) < 8) begin
                if ($urandom_range(0, 3) != 0)
                    queue_item(OP_CLEAR, 8'($urandom));
                if ($urandom_range(0, 3) == 0) begin
                    foreach (perm[i])
                        perm[i] = i;
                    for (int k = LETTERS - 1; k > 0; k--) begin
                        j = $urandom_range(0, k);
                        tmp = perm[k];
                        perm[k] = perm[j];
                        perm[j] = tmp;
                    end
                    foreach (perm[i])
                        queue_item(OP_KEY, 8'(int'(ASCII_A) + perm[i]));
                end else begin
                    klen = $urandom_range(0, 12);
                    for (int k = 0; k < klen; k++) begin
                        if ($urandom_range(0, 9) == 0)
                            queue_item(OP_KEY, 8'($urandom));
                        else
                            queue_item(OP_KEY, any_letter());
                    end
                end
                clen = $urandom_range(4, 16);
                for (int k = 0; k < clen; k++) begin
                    if ($urandom_range(0, 9) == 0)
                        queue_item(OP_CIPHER, 8'($urandom));
                    else
                        queue_item(OP_CIPHER, any_letter());
                end
            end else begin
                klen = $urandom_range(1, 4);
                for (int k = 0; k < klen; k++)
                    queue_item(2'($urandom_range(0, 3)), 8'($urandom));
            end
        end
        n_items = feed_q.size();

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (sent_cnt < n_items)
            @(posedge aclk);
        while (plain_q.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("tb: %0d transactions in, %0d letters deciphered, %0d mismatches",
                 sent_cnt, recv_cnt, err_cnt);
        $display("tb: %0d clears, %0d key letters kept, %0d complete 26-letter keys",
                 clear_cnt, key_cnt, full_key_cnt);
        if (err_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
`default_nettype wire
